>>> rtl/graph_m_coloring_check_top_macros.svh
// Assertion macros for the top-level RTL.
`ifndef GRAPH_M_COLORING_CHECK_TOP_MACROS_SVH
`define GRAPH_M_COLORING_CHECK_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define GMC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define GMC_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define GMC_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define GMC_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif

`endif

>>> rtl/gmc_pkg.sv
package gmc_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int ROW_W         = 32;
    localparam int IDX_W         = 5;
    localparam int COLOR_W       = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLORS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES  = 1'd1;

    localparam logic [COLOR_W-1:0] NUM_COLORS_RST = 6'd3;
    localparam logic [COLOR_W-1:0] NUM_NODES_RST  = 6'd4;

    typedef struct packed {
        logic clear_all;
        logic wr_en;
    } col_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ok;
    } srch_stat_t;

endpackage

>>> rtl/gmc_channels.sv
interface gmc_row_if
    import gmc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
    logic             last_row;

    modport source (output valid, output row_index, output row_bits, output last_row,
                    input ready);
    modport sink   (input valid, input row_index, input row_bits, input last_row,
                    output ready);
endinterface

interface gmc_result_if;
    logic valid;
    logic ready;
    logic colorable;

    modport source (output valid, output colorable, input ready);
    modport sink   (input valid, input colorable, output ready);
endinterface

>>> rtl/graph_m_coloring_check_top.sv
// Graph m-coloring checker.
// rows: one beat loads adjacency row row_index (bit j = edge to node j).
//   Rows at or above MAX_NODES are dropped. A beat with last_row set stores
//   its row and then starts a backtracking search over nodes
//   0..min(num_nodes, MAX_NODES)-1 with colors 1..num_colors.
// result: one beat per last row, colorable = 1 when a valid coloring exists.
// Config: cfg_we/cfg_index/cfg_data, index 0 num_colors, 1 num_nodes;
//   write only while no search is running.
// Rows that are not last are taken whenever no search is running.
// Search: each attempt of a color on node v reads the earlier nodes in order
//   through the shared color/adjacency read address, via S_TRY and S_CHK for
//   each node compared, until a conflict or until all are passed; each step
//   forward or back passes S_NODE and S_SETC. The total follows the backtracking
//   tree and can grow exponentially. rows.ready is low meanwhile.
// Stall: the result sits in an output register; the next row beats are taken
//   while it waits, and a later search holds its flag until the register frees.
// Reset: num_colors = 3, num_nodes = 4, all nodes uncolored, no result pending.
//   Adjacency rows are undefined until loaded.
`include "graph_m_coloring_check_top_macros.svh"

module graph_m_coloring_check_top
    import gmc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    gmc_row_if.sink                rows,
    gmc_result_if.source           result,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [COLOR_W-1:0] num_colors_reg;
    logic [COLOR_W-1:0] num_nodes_reg;
    logic               out_valid_reg;
    logic               out_flag_reg;

    srch_stat_t         stat;
    col_ctl_t           col_ctl;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic [ROW_W-1:0]   adj_data;
    logic [COLOR_W-1:0] col_data;
    logic               row_beat;
    logic               row_store;
    logic               start;
    logic               out_free;

    assign rows.ready = !stat.busy;
    assign row_beat   = rows.valid && rows.ready;
    assign row_store  = row_beat && (32'(rows.row_index) < MAX_NODES);
    assign start      = row_beat && rows.last_row;
    assign out_free   = !out_valid_reg || result.ready;

    assign result.valid     = out_valid_reg;
    assign result.colorable = out_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_colors_reg <= NUM_COLORS_RST;
            num_nodes_reg  <= NUM_NODES_RST;
            out_valid_reg  <= 1'b0;
            out_flag_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_COLORS: num_colors_reg <= cfg_data;
                    CFG_NUM_NODES:  num_nodes_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            if (stat.done)
            begin
                out_valid_reg <= 1'b1;
                out_flag_reg  <= stat.ok;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    gmc_adj_mem #(
        .MAX_NODES(MAX_NODES)
    ) u_adj_mem (
        .clk     (clk),
        .wr_en   (row_store),
        .wr_addr (AW'(rows.row_index)),
        .wr_data (rows.row_bits),
        .rd_addr (rd_addr),
        .rd_data (adj_data)
    );

    gmc_color_mem #(
        .MAX_NODES(MAX_NODES)
    ) u_color_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (col_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (col_data)
    );

    gmc_search #(
        .MAX_NODES(MAX_NODES)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .out_free   (out_free),
        .num_colors (num_colors_reg),
        .num_nodes  (num_nodes_reg),
        .adj_data   (adj_data),
        .col_data   (col_data),
        .rd_addr    (rd_addr),
        .col_ctl    (col_ctl),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .stat       (stat)
    );

    `GMC_ASSERT_IMP(a_busy_blocks_rows, clk, rst_n, stat.busy, !rows.ready)
    `GMC_ASSERT_NXT(a_last_starts_search, clk, rst_n, start, stat.busy)
    `GMC_ASSERT_NXT(a_done_shows_result, clk, rst_n, stat.done, result.valid)
endmodule

>>> rtl/gmc_adj_mem.sv
module gmc_adj_mem
    import gmc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [ROW_W-1:0]      wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [ROW_W-1:0]      rd_data
);
    logic [ROW_W-1:0] mem [MAX_NODES];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

>>> rtl/gmc_color_mem.sv
module gmc_color_mem
    import gmc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  col_ctl_t            ctl,
    input  logic [AW-1:0]       wr_addr,
    input  logic [COLOR_W-1:0]  wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic [COLOR_W-1:0]  rd_data
);
    logic [COLOR_W-1:0]   mem [MAX_NODES];
    logic [MAX_NODES-1:0] valid_reg;
    logic [COLOR_W-1:0]   rd_data_reg;
    logic                 rd_valid_reg;

    // entries not written since the last clear read as uncolored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;
endmodule

>>> rtl/gmc_search.sv
module gmc_search
    import gmc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 out_free,
    input  logic [COLOR_W-1:0]   num_colors,
    input  logic [COLOR_W-1:0]   num_nodes,
    input  logic [ROW_W-1:0]     adj_data,
    input  logic [COLOR_W-1:0]   col_data,
    output logic [AW-1:0]        rd_addr,
    output col_ctl_t             col_ctl,
    output logic [AW-1:0]        wr_addr,
    output logic [COLOR_W-1:0]   wr_data,
    output srch_stat_t           stat
);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NODE,
        S_SETC,
        S_TRY,
        S_CHK,
        S_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      v_reg, v_next;
    logic [CW-1:0]      u_reg, u_next;
    logic [COLOR_W:0]   c_reg, c_next;
    logic               ok_reg, ok_next;

    logic [CW-1:0]      n_sat;
    logic               over;
    logic               edge_bit;
    logic               conflict;

    assign n_sat = (32'(num_nodes) > MAX_NODES) ? CW'(MAX_NODES) : CW'(num_nodes);
    assign over  = c_reg > {1'b0, num_colors};
    // columns past the row width carry no edge
    assign edge_bit = (32'(v_reg) < ROW_W) ? adj_data[5'(v_reg)] : 1'b0;
    assign conflict = edge_bit && ({1'b0, col_data} == c_reg);

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        u_next     = u_reg;
        c_next     = c_reg;
        ok_next    = ok_reg;
        rd_addr    = u_reg[AW-1:0];
        col_ctl    = '0;
        wr_addr    = v_reg[AW-1:0];
        wr_data    = '0;
        stat.busy  = (state_reg != S_IDLE);
        stat.done  = 1'b0;
        stat.ok    = ok_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    col_ctl.clear_all = 1'b1;
                    v_next            = '0;
                    state_next        = S_NODE;
                end
            end
            S_NODE:
            begin
                rd_addr = v_reg[AW-1:0];
                if (v_reg >= n_sat)
                begin
                    ok_next    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SETC;
                end
            end
            S_SETC:
            begin
                c_next     = {1'b0, col_data} + 1'b1;
                u_next     = '0;
                state_next = S_TRY;
            end
            S_TRY:
            begin
                priority if (over)
                begin
                    col_ctl.wr_en = 1'b1;
                    if (v_reg == '0)
                    begin
                        ok_next    = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        v_next     = v_reg - 1'b1;
                        state_next = S_NODE;
                    end
                end
                else if (u_reg == v_reg)
                begin
                    col_ctl.wr_en = 1'b1;
                    wr_data       = c_reg[COLOR_W-1:0];
                    v_next        = v_reg + 1'b1;
                    state_next    = S_NODE;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (conflict)
                begin
                    c_next = c_reg + 1'b1;
                    u_next = '0;
                end
                else
                begin
                    u_next = u_reg + 1'b1;
                end
                state_next = S_TRY;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            v_reg     <= '0;
            u_reg     <= '0;
            c_reg     <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            u_reg     <= u_next;
            c_reg     <= c_next;
            ok_reg    <= ok_next;
        end
    end
endmodule

>>> tb/testbench.sv
module testbench;
    import gmc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXN          = MAX_NODES_DEF;
    localparam int SEARCH_BUDGET = 6000;
    localparam int HOLD_CYCLES   = 500;

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        row_t             bits;
        logic             last;
    } beat_t;

    class coloring_scoreboard;
        row_t        adjacency [MAXN];
        int unsigned ncolors;
        int unsigned nnodes;
        bit          expected_colorable [$];
        int unsigned errors;
        int unsigned searches;
        int unsigned found;

        function new();
            ncolors  = NUM_COLORS_RST;
            nnodes   = NUM_NODES_RST;
            errors   = 0;
            searches = 0;
            found    = 0;
            foreach (adjacency[i])
                adjacency[i] = '0;
        endfunction

        // Depth-first search in node order; cost is a rough cycle estimate.
        function bit try_coloring(input row_t adj [MAXN], input int unsigned m,
                                  input int unsigned n, input int unsigned budget,
                                  output int unsigned cost);
            int unsigned hue [MAXN];
            int unsigned v;
            int unsigned c;
            bit          placed;
            bit          ok;
            cost = 0;
            if (n > MAXN)
                n = MAXN;
            foreach (hue[i])
                hue[i] = 0;
            v = 0;
            forever
            begin
                if (v >= n)
                    return 1'b1;
                if (cost > budget)
                    return 1'b0;
                placed = 1'b0;
                for (c = hue[v] + 1; c <= m && !placed; c++)
                begin
                    cost += 2 * v + 4;
                    ok = 1'b1;
                    for (int unsigned u = 0; u < v; u++)
                        if (hue[u] == c && adj[u][v])
                            ok = 1'b0;
                    if (ok)
                    begin
                        hue[v] = c;
                        placed = 1'b1;
                    end
                end
                if (placed)
                    v++;
                else
                begin
                    cost += 4;
                    hue[v] = 0;
                    if (v == 0)
                        return 1'b0;
                    v--;
                end
            end
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_NUM_COLORS)
                ncolors = val;
            else if (idx == CFG_NUM_NODES)
                nnodes = val;
        endfunction

        function void note_row(input logic [IDX_W-1:0] idx, input row_t bits, input bit last);
            int unsigned cost;
            bit          flag;
            if (idx < MAXN)
                adjacency[idx] = bits;
            if (last)
            begin
                flag = try_coloring(adjacency, ncolors, nnodes, 32'hFFFF_FFFF, cost);
                expected_colorable.push_back(flag);
                searches++;
                if (flag)
                    found++;
            end
        endfunction

        function void check_flag(input bit colorable);
            bit want;
            if (expected_colorable.size() == 0)
            begin
                $error("result beat with nothing expected: colorable=%0b", colorable);
                errors++;
                return;
            end
            want = expected_colorable.pop_front();
            if (want !== colorable)
            begin
                $error("colorable mismatch: expected %0b actual %0b", want, colorable);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gmc_row_if    rows_if ();
    gmc_result_if res_if ();

    graph_m_coloring_check_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows      (rows_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    coloring_scoreboard sb;
    bit                 written [MAXN];
    bit                 tx_calm;
    bit                 hold_ask;
    int unsigned        beats;
    int unsigned        settings;
    int unsigned        holds;

    int unsigned fix_m [11] = '{3, 2, 0, 4, 32, 63, 1, 3, 5, 2, 32};
    int unsigned fix_n [11] = '{6, 8, 5, 0, 32, 63, 6, 40, 5, 16, 1};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic row_t rand_row(input int unsigned thin);
        row_t r;
        if (thin >= 6)
            return '0;
        r = $urandom;
        repeat (thin) r &= $urandom;
        if (thin == 0 && $urandom_range(7) == 0)
            r = $urandom_range(1) ? '1 : '0;
        return r;
    endfunction

    task automatic send_beat(input logic [IDX_W-1:0] idx, input row_t bits, input bit last);
        while (!tx_calm && $urandom_range(99) < 6)
        begin
            rows_if.valid <= 1'b0;
            @(posedge clk);
        end
        rows_if.valid     <= 1'b1;
        rows_if.row_index <= idx;
        rows_if.row_bits  <= bits;
        rows_if.last_row  <= last;
        @(posedge clk);
        while (!rows_if.ready)
            @(posedge clk);
        sb.note_row(idx, bits, last);
        written[idx] = 1'b1;
        beats++;
    endtask

    task automatic drain();
        rows_if.valid <= 1'b0;
        while (sb.expected_colorable.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input int unsigned m, input int unsigned n);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_COLORS;
        cfg_data  <= m[CFG_DATA_W-1:0];
        @(posedge clk);
        sb.set_reg(CFG_NUM_COLORS, m[CFG_DATA_W-1:0]);
        cfg_index <= CFG_NUM_NODES;
        cfg_data  <= n[CFG_DATA_W-1:0];
        @(posedge clk);
        sb.set_reg(CFG_NUM_NODES, n[CFG_DATA_W-1:0]);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Rows of unwritten nodes in use are loaded before the last beat, others at
    // random; dense graphs are thinned until the search stays short.
    task automatic run_sequence(input bit whole);
        beat_t       plan [$];
        beat_t       tail;
        row_t        cand [MAXN];
        int unsigned neff;
        int unsigned thin;
        int unsigned cost;
        bit          full;
        neff = (sb.nnodes > MAXN) ? MAXN : sb.nnodes;
        thin = $urandom_range(3);
        full = 1'b0;
        forever
        begin
            plan.delete();
            cand = sb.adjacency;
            for (int unsigned k = 0; k < neff; k++)
                if (full || !written[k] || $urandom_range(1) == 1)
                    plan.push_back('{k[IDX_W-1:0], rand_row(thin), 1'b0});
            plan.shuffle();
            if (!whole)
                break;
            tail = '{IDX_W'($urandom_range(31)), rand_row(thin), 1'b1};
            plan.push_back(tail);
            foreach (plan[i])
                cand[plan[i].idx] = plan[i].bits;
            void'(sb.try_coloring(cand, sb.ncolors, sb.nnodes, SEARCH_BUDGET, cost));
            if (cost <= SEARCH_BUDGET)
                break;
            full = 1'b1;
            thin++;
        end
        foreach (plan[i])
            send_beat(plan[i].idx, plan[i].bits, plan[i].last);
    endtask

    initial
    begin
        int unsigned hold_left;
        int unsigned cyc;
        hold_left = 0;
        cyc       = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rst_n && res_if.valid && res_if.ready)
                sb.check_flag(res_if.colorable);
            if (hold_ask)
            begin
                hold_left = HOLD_CYCLES;
                hold_ask  = 1'b0;
                holds++;
            end
            if (hold_left != 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
                res_if.ready <= ((cyc % 8000) < 2000) || ($urandom_range(99) >= 6);
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned m;
        int unsigned n;
        int unsigned nseq;
        int unsigned pick;
        sb       = new();
        tx_calm  = 1'b0;
        hold_ask = 1'b0;
        beats    = 0;
        settings = 0;
        holds    = 0;
        foreach (written[i])
            written[i] = 1'b0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_NUM_COLORS;
        cfg_data          <= '0;
        rows_if.valid     <= 1'b0;
        rows_if.row_index <= '0;
        rows_if.row_bits  <= '0;
        rows_if.last_row  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // complete graph on four nodes with the reset setting of three colors
        send_beat(0, '1, 1'b0);
        send_beat(1, '1, 1'b0);
        send_beat(2, '1, 1'b0);
        send_beat(3, '1, 1'b1);
        send_beat(0, '0, 1'b1);
        // last beat on a row outside the nodes in use
        send_beat(31, '1, 1'b0);
        send_beat(31, '0, 1'b1);
        drain();
        configure(0, 4);
        send_beat(2, '0, 1'b1);
        drain();
        configure(0, 0);
        send_beat(0, '1, 1'b1);
        drain();
        configure(1, 2);
        send_beat(0, 32'h0000_0002, 1'b1);
        send_beat(0, 32'hFFFF_FFFD, 1'b1);
        drain();
        // greedy choice fails, backtracking finds a coloring
        configure(2, 4);
        send_beat(0, 32'h0000_0004, 1'b0);
        send_beat(1, 32'h0000_0008, 1'b0);
        send_beat(2, 32'h0000_0008, 1'b0);
        send_beat(3, $urandom, 1'b1);
        drain();
        configure(2, 3);
        send_beat(0, 32'h0000_0006, 1'b0);
        send_beat(1, 32'h0000_0004, 1'b1);
        drain();

        phase = 0;
        while (beats < 1270)
        begin
            if (phase < 11)
            begin
                m = fix_m[phase];
                n = fix_n[phase];
            end
            else if ($urandom_range(7) == 0)
            begin
                m = $urandom_range(63);
                n = $urandom_range(63);
            end
            else
            begin
                m = $urandom_range(1, 6);
                n = $urandom_range(1, 12);
            end
            configure(m, n);
            tx_calm = (phase % 4 == 3);
            if (phase == 1)
                hold_ask = 1'b1;
            nseq = (n > 16) ? $urandom_range(2, 4) : $urandom_range(8, 20);
            for (int unsigned s = 0; s < nseq; s++)
            begin
                pick = $urandom_range(99);
                if (s == nseq - 1 || pick >= 20)
                    run_sequence(1'b1);
                else if (pick < 10)
                    send_beat(IDX_W'($urandom_range(31)), rand_row(0), 1'b0);
                else
                    run_sequence(1'b0);
            end
            drain();
            phase++;
        end

        $display("run covered %0d row beats, %0d searches (%0d colorable), %0d settings",
                 beats, sb.searches, sb.found, settings);
        $display("receiver hold-offs: %0d, mismatches: %0d", holds, sb.errors);
        if (sb.errors == 0 && sb.expected_colorable.size() == 0)
            $display("** graph_m_coloring_check_top: PASSED **");
        else
            $display("** graph_m_coloring_check_top: FAILED **");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("** graph_m_coloring_check_top: FAILED **");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/gmc_pkg.sv
rtl/gmc_channels.sv
rtl/gmc_adj_mem.sv
rtl/gmc_color_mem.sv
rtl/gmc_search.sv
rtl/graph_m_coloring_check_top.sv
tb/testbench.sv
